/* src/ccs_pkg.sv */
// ---------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the config comment stripper
// Scanner modes, character codes and the per-byte step record.
// ---------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_QUOTE  = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_STAR   = 3'd5
  } mode_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam logic [7:0] CC_A_RESET = 8'd59;
  localparam logic [7:0] CC_B_RESET = 8'd35;
  localparam logic [7:0] CC_C_RESET = 8'd0;
  localparam logic [7:0] CC_D_RESET = 8'd0;

  // register indexes of the configuration port
  localparam logic [7:0] REG_CC_A = 8'd0;
  localparam logic [7:0] REG_CC_B = 8'd1;
  localparam logic [7:0] REG_CC_C = 8'd2;
  localparam logic [7:0] REG_CC_D = 8'd3;

  // results of one byte plus the line filter state
  typedef struct packed {
    logic       lhc;   // line has content
    logic       nlp;   // newline held back
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } step_t;

  typedef struct packed {
    logic       last;
    logic       valid;
    logic [7:0] data;
  } out_ent_t;

  function automatic step_t emit(step_t s, logic [7:0] b);
    step_t r;
    r = s;
    case (s.cnt)
      2'd0: begin r.b0 = b; r.cnt = 2'd1; end
      2'd1: begin r.b1 = b; r.cnt = 2'd2; end
      2'd2: begin r.b2 = b; r.cnt = 2'd3; end
      default: r = s;
    endcase
    return r;
  endfunction

  // line filter: drop empty lines, hold a newline until content follows
  function automatic step_t put_byte(step_t s, logic [7:0] b);
    step_t r;
    r = s;
    if (b == CH_NL) begin
      if (r.lhc) begin
        r.nlp = 1'b1;
        r.lhc = 1'b0;
      end
    end else begin
      if (r.nlp) begin
        r = emit(r, CH_NL);
        r.nlp = 1'b0;
      end
      r = emit(r, b);
      r.lhc = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/config_comment_stripper.sv */
// ---------------------------------------------------------------------------
// config_comment_stripper: comment and blank line stripper for config text
// Drops comments, spaces and empty lines from a byte stream; quotes pass.
// ---------------------------------------------------------------------------
// Results are written into the output queue registers and presented from its
// head. Throughput: one input byte per cycle while out_tready stays high and
// each byte yields at most one result; in_tready needs at most one result
// still buffered in the 4-entry output queue, so a byte yielding two or three
// results holds the input off until the queue drains. rst_n (synchronous)
// empties the queue, returns the scanner to normal mode and loads the comment characters ; # 0 0.
`default_nettype none

module config_comment_stripper #(
  parameter int QDEPTH = 4              // output queue depth, power of two, >= 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] in_byte
  input  wire logic       in_tlast,     // in_last
  // result stream
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,    // [7:0] out_byte
  output      logic       out_tuser,    // [0] byte_valid
  output      logic       out_tlast,    // out_last
  // configuration writes
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  import ccs_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = PW + 1;

  // comment character registers
  logic [7:0] cc_a_r, cc_b_r, cc_c_r, cc_d_r;

  // scanner state
  mode_t      mode_r, mode_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic       esc_r, esc_nxt;
  logic       lhc_r, lhc_nxt;
  logic       nlp_r, nlp_nxt;

  // output queue
  out_ent_t        q_mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  logic       in_acc, out_acc;
  logic [7:0] b;
  logic       is_cc;
  step_t      s;
  logic [1:0] push_cnt;
  logic       marker;

  assign cfg_ready  = 1'b1;
  // room for the worst case of three results per byte
  assign in_tready  = (count_r <= CW'(QDEPTH - 3));
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_acc    = out_tvalid && out_tready;

  assign out_tdata  = q_mem[rd_ptr_r].data;
  assign out_tuser  = q_mem[rd_ptr_r].valid;
  assign out_tlast  = q_mem[rd_ptr_r].last;

  assign b     = in_tdata;
  assign is_cc = (b != 8'd0) &&
                 ((b == cc_a_r) || (b == cc_b_r) || (b == cc_c_r) || (b == cc_d_r));

  // ---- per-byte scan step ----
  always_comb begin
    logic do_normal;
    s         = '0;
    s.lhc     = lhc_r;
    s.nlp     = nlp_r;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    do_normal = 1'b0;

    unique case (mode_r)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (b == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          // lone slash goes out, then the byte is scanned normally
          s         = put_byte(s, CH_SLASH);
          mode_nxt  = MODE_NORMAL;
          do_normal = 1'b1;
        end
      end
      MODE_QUOTE: begin
        s = put_byte(s, b);
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (b == CH_BSL) begin
          esc_nxt = 1'b1;
        end else if (b == quote_r) begin
          mode_nxt  = MODE_NORMAL;
          quote_nxt = 8'd0;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) begin
          s        = put_byte(s, CH_NL);
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) mode_nxt = MODE_STAR;
      end
      MODE_STAR: begin
        if (b == CH_SLASH)     mode_nxt = MODE_NORMAL;
        else if (b != CH_STAR) mode_nxt = MODE_BLOCK;
      end
      default: begin
        mode_nxt  = MODE_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      // priority: quote, comment character, slash, whitespace
      if ((b == CH_BTICK) || (b == CH_SQUOT) || (b == CH_DQUOT)) begin
        s         = put_byte(s, b);
        quote_nxt = b;
        esc_nxt   = 1'b0;
        mode_nxt  = MODE_QUOTE;
      end else if ((b != CH_NL) && is_cc) begin
        mode_nxt = MODE_LINE;
      end else if (b == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else if ((b > CH_SPACE) || (b == CH_NL) || (b == CH_TAB)) begin
        s = put_byte(s, b);
      end
    end

    // end of text closes everything; a slash still open is emitted
    if (in_tlast) begin
      if (mode_nxt == MODE_SLASH) s = put_byte(s, CH_SLASH);
      mode_nxt  = MODE_NORMAL;
      quote_nxt = 8'd0;
      esc_nxt   = 1'b0;
      s.lhc     = 1'b0;
      s.nlp     = 1'b0;
    end

    lhc_nxt = s.lhc;
    nlp_nxt = s.nlp;
  end

  assign marker   = in_tlast && (s.cnt == 2'd0);
  assign push_cnt = in_acc ? (marker ? 2'd1 : s.cnt) : 2'd0;

  assign count_nxt = count_r + CW'(push_cnt) - CW'(out_acc);

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      quote_r  <= 8'd0;
      esc_r    <= 1'b0;
      lhc_r    <= 1'b0;
      nlp_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      cc_a_r   <= CC_A_RESET;
      cc_b_r   <= CC_B_RESET;
      cc_c_r   <= CC_C_RESET;
      cc_d_r   <= CC_D_RESET;
    end else begin
      if (in_acc) begin
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
        esc_r   <= esc_nxt;
        lhc_r   <= lhc_nxt;
        nlp_r   <= nlp_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PW'(push_cnt);
      if (out_acc) rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CC_A: cc_a_r <= cfg_data;
          REG_CC_B: cc_b_r <= cfg_data;
          REG_CC_C: cc_c_r <= cfg_data;
          REG_CC_D: cc_d_r <= cfg_data;
          default: ;   // writes beyond the register list are dropped
        endcase
      end
    end
  end

  // ---- queue payload, no reset ----
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(push_cnt)) begin
        q_mem[wr_ptr_r + PW'(k)].data  <= marker ? 8'd0 :
                                          (k == 0) ? s.b0 : (k == 1) ? s.b1 : s.b2;
        q_mem[wr_ptr_r + PW'(k)].valid <= !marker;
        q_mem[wr_ptr_r + PW'(k)].last  <= in_tlast && (k == int'(push_cnt) - 1);
      end
    end
  end

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("output queue overflow");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> (mode_r == MODE_NORMAL) && !lhc_r && !nlp_r && !esc_r)
    else $error("scanner state not cleared after end of text");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("end marker without out_tlast");

  a_esc_in_quote: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == MODE_QUOTE))
    else $error("escape pending outside quoted text");

endmodule

`default_nettype wire
